@@ rtl/assert_macros.svh @@
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked assertion, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, checked through reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/atsc_pkg.sv @@
package atsc_pkg;

  // configuration port
  localparam int CFG_ADDR_W = 8;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_DRIVE_GAIN = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE_GAIN = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_MIX    = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_AUTO_LEVEL = 8'd3;

  // blend weight of 1.0 in q1.15
  localparam logic [CFG_DATA_W-1:0] MIX_ONE = 16'd32768;

  // gain is the product of two 16 bit registers
  localparam int GAIN_W = 32;

  // cordic datapath
  localparam int CORDIC_STAGES  = 24;
  localparam int ANGLE_ONE_BITS = 30;
  localparam int CORDIC_XY_W    = 50;
  localparam int ANGLE_W        = 32;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  // atan(2^-i) * 2/pi, 1.0 = 2^30
  localparam angle_t ATAN_TAB [0:CORDIC_STAGES-1] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

endpackage

@@ rtl/atan_soft_clip_distortion_unit.sv @@
// Arctangent soft clip distortion for a stream of signed q1.15 audio samples.
// Samples enter on the s_* stream and results leave on the m_* stream, one
// result per sample, in order. Each sample is scaled by drive_gain * range_gain,
// passed through a 24 stage vectoring cordic that gives atan scaled by 2/pi,
// and blended with the clean sample by wet_mix. With auto_level set and a gain
// above 4.0 the blend is divided by four. The result is rounded and saturated.
// Configuration goes through cfg_we / cfg_addr / cfg_wdata and must only be
// written while no sample is in flight.
// Throughput: one sample per cycle unless the output stalls, set by the fully
// pipelined datapath of 30 register stages (input, gain multiply, argument, 24
// cordic steps, blend multiply, blend sum, round and saturate).
// A result shows on m_tvalid when it reaches obuf, the last of these stages.
// Stall: when m_tvalid is high and m_tready low the whole pipeline holds and
// s_tready drops; nothing is lost or repeated. A bubble never blocks input.
// Reset: rst clears all valid bits and the registers (gain 0, mix 0, auto off).
module atan_soft_clip_distortion_unit
  import atsc_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // sample stream in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,  // [SAMPLE_WIDTH-1:0] sample_in
  // sample stream out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,  // [SAMPLE_WIDTH-1:0] sample_out
  // configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  `include "assert_macros.svh"

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DW    = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PW    = SAMPLE_WIDTH + GAIN_W;
  localparam int EW    = PW + 16;
  localparam int AFRAC = SAMPLE_WIDTH - 1 + 2 * GAIN_FRAC_BITS;
  localparam int XW    = CORDIC_XY_W;
  localparam int NC    = CORDIC_STAGES;
  localparam int NST   = 3 + CORDIC_STAGES + 3;
  localparam int PRW   = ANGLE_W + 17;
  localparam int MXW   = 36;
  localparam int K     = ANGLE_ONE_BITS + 1 - SAMPLE_WIDTH;
  localparam logic signed [MXW-1:0] SAT_HI = {{(MXW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [MXW-1:0] SAT_LO = ~SAT_HI;

  // configuration registers
  logic [CFG_DATA_W-1:0] drive_gain;
  logic [CFG_DATA_W-1:0] range_gain;
  logic [CFG_DATA_W-1:0] wet_mix;
  logic                  auto_level;
  logic [GAIN_W-1:0]     gain;
  logic                  gain_big;

  // pipeline control
  logic [NST-1:0] vld;
  logic           adv;

  // front stages
  logic [SW-1:0]        s_raw;
  logic signed [SW-1:0] s0;
  logic [SW-1:0]        mag0;
  logic signed [SW-1:0] s1;
  logic [PW-1:0]        prod1;
  logic [EW-1:0]        arg_full;
  logic [30:0]          arg;

  // cordic stages, index 0 is the initial vector
  logic signed [XW-1:0] cx [0:NC];
  logic signed [XW-1:0] cy [0:NC];
  angle_t               cz [0:NC];
  logic signed [SW-1:0] cs [0:NC];

  // blend and output stages
  angle_t                wet_w;
  angle_t                dry_w;
  logic signed [16:0]    wet_wt;
  logic signed [16:0]    dry_wt;
  logic signed [PRW-1:0] pw;
  logic signed [PRW-1:0] pd;
  logic signed [PRW:0]   mix_sum;
  logic signed [PRW:0]   mix_w;
  logic signed [MXW-1:0] mix2;
  logic signed [MXW-1:0] rnd_w;
  logic [SW-1:0]         sat_w;
  logic [SW-1:0]         obuf;

  // register writes, wet_mix clamped to MIX_ONE
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain <= '0;
      range_gain <= '0;
      wet_mix    <= '0;
      auto_level <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_DRIVE_GAIN: drive_gain <= cfg_wdata;
        REG_RANGE_GAIN: range_gain <= cfg_wdata;
        REG_WET_MIX:    wet_mix    <= (cfg_wdata > MIX_ONE) ? MIX_ONE : cfg_wdata;
        REG_AUTO_LEVEL: auto_level <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // gain product and auto level threshold follow the registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain     <= '0;
      gain_big <= 1'b0;
    end else begin
      gain     <= drive_gain * range_gain;
      gain_big <= {32'd0, gain} > (64'd4 << (2 * GAIN_FRAC_BITS));
    end
  end

  // whole pipeline moves unless the output holds an untaken result
  assign adv      = !vld[NST-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  // atan argument: truncate to q16.16 and saturate
  assign s_raw    = s_tdata[SW-1:0];
  assign arg_full = {prod1, 16'd0} >> AFRAC;
  assign arg      = (|arg_full[EW-1:31]) ? 31'h7FFF_FFFF : arg_full[30:0];

  // input, gain multiply and cordic initial vector
  always_ff @(posedge clk) begin
    if (adv) begin
      s0    <= s_raw;
      mag0  <= s_raw[SW-1] ? (~s_raw + 1'b1) : s_raw;
      s1    <= s0;
      prod1 <= mag0 * gain;
      cx[0] <= XW'(64'd1 << 32);
      cy[0] <= {3'b000, arg, 16'd0};
      cz[0] <= '0;
      cs[0] <= s1;
    end
  end

  // one vectoring rotation per stage
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        cs[i+1] <= cs[i];
        if (!cy[i][XW-1]) begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_TAB[i];
        end else begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_TAB[i];
        end
      end
    end
  end

  // wet is the signed angle, dry is the clean sample at 30 fraction bits
  assign wet_w  = cs[NC][SW-1] ? -cz[NC] : cz[NC];
  assign wet_wt = {1'b0, wet_mix};
  assign dry_wt = 17'sd32768 - {1'b0, wet_mix};

  if (SAMPLE_WIDTH <= ANGLE_ONE_BITS + 1) begin : g_dry_up
    assign dry_w = ANGLE_W'(cs[NC]) <<< (ANGLE_ONE_BITS + 1 - SAMPLE_WIDTH);
  end else begin : g_dry_down
    assign dry_w = ANGLE_W'(cs[NC] >>> (SAMPLE_WIDTH - 1 - ANGLE_ONE_BITS));
  end

  // blend sum, floor by 2^15, optional floor divide by four
  assign mix_sum = pw + pd;
  always_comb begin
    mix_w = mix_sum >>> 15;
    if (auto_level && gain_big) begin
      mix_w = mix_w >>> 2;
    end
  end

  // round half up to the sample fraction
  if (K > 0) begin : g_rnd_down
    localparam logic signed [MXW-1:0] RND = {{(MXW-1){1'b0}}, 1'b1} << (K - 1);
    assign rnd_w = (mix2 + RND) >>> K;
  end else if (K == 0) begin : g_rnd_none
    assign rnd_w = mix2;
  end else begin : g_rnd_up
    assign rnd_w = mix2 <<< (-K);
  end

  // saturate to the sample range
  always_comb begin
    if (rnd_w > SAT_HI) begin
      sat_w = SAT_HI[SW-1:0];
    end else if (rnd_w < SAT_LO) begin
      sat_w = SAT_LO[SW-1:0];
    end else begin
      sat_w = rnd_w[SW-1:0];
    end
  end

  // blend multiply, blend sum and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      pw   <= wet_w * wet_wt;
      pd   <= dry_w * dry_wt;
      mix2 <= mix_w[MXW-1:0];
      obuf <= sat_w;
    end
  end

  assign m_tdata = DW'(obuf);

  // an accepted transaction lands in the first stage
  `ASSERT_CLK(a_accept_load, clk, rst, s_tvalid && s_tready |=> vld[0], "accepted sample not in stage 0")
  // a stall freezes every valid bit
  `ASSERT_CLK(a_stall_hold, clk, rst, !adv |=> $stable(vld), "valid bits moved during stall")
  // the last inner stage feeds the output register
  `ASSERT_CLK(a_out_load, clk, rst, adv && vld[NST-2] |=> m_tvalid, "result lost before output")
  // reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> vld == '0, "pipeline not empty after reset")

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import atsc_pkg::*;

  localparam int SW           = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 150;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [SW-1:0]   s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [SW-1:0]   m_tdata;
  logic            cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the register file
  int drive_q = 0;
  int range_q = 0;
  int wet_q   = 0;
  bit auto_q  = 1'b0;

  logic [SW-1:0] dry_samples[$];
  logic [SW-1:0] shaped_samples[$];
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  idle_off = 1'b0;
  bit  long_hold_req = 1'b0;

  atan_soft_clip_distortion_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [15:0] sample_in
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // [15:0] sample_out
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // gain, atan soft clip by cordic, dry/wet blend, auto level, round, saturate
  function automatic logic [SW-1:0] soft_clip(input logic [SW-1:0] raw);
    logic   neg;
    longint s, gain, mag, arg, x, y, z, xs, ys, wet, dry, mix, res;
    int     i;
    neg  = raw[SW-1];
    s    = longint'($signed(raw));
    gain = longint'(drive_q) * longint'(range_q);
    mag  = (neg ? -s : s) * gain;
    // q1.15 times q16.16 down to a q16.16 argument, saturated
    arg  = mag >>> 15;
    if (arg > 64'sd2147483647) begin
      arg = 64'sd2147483647;
    end
    x = 64'sd1 <<< 32;
    y = arg <<< 16;
    z = 0;
    for (i = 0; i < CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_TAB[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_TAB[i];
      end
    end
    wet = neg ? -z : z;
    dry = s <<< (ANGLE_ONE_BITS - (SW - 1));
    mix = (wet * longint'(wet_q) + dry * longint'(32768 - wet_q)) >>> 15;
    if (auto_q && gain > (64'sd4 <<< 16)) begin
      mix = mix >>> 2;
    end
    res = (mix + 64'sd16384) >>> 15;
    if (res > 64'sd32767) begin
      res = 64'sd32767;
    end
    if (res < -64'sd32768) begin
      res = -64'sd32768;
    end
    return res[SW-1:0];
  endfunction

  // no gap half the time (always while idle_off is set), else mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 50) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // sample source: one transaction per handshake
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        shaped_samples.push_back(soft_clip(s_tdata));
        in_gap = pick_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (in_gap > 0 || dry_samples.size() == 0) begin
          if (in_gap > 0) begin
            in_gap--;
          end
          s_tvalid <= 1'b0;
        end else begin
          s_tvalid <= 1'b1;
          s_tdata  <= dry_samples.pop_front();
        end
      end
    end
  end

  // result sink and compare
  always @(posedge clk) begin
    logic [SW-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (shaped_samples.size() == 0) begin
          $display("%0t: unexpected sample, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          want = shaped_samples.pop_front();
          if (m_tdata !== want) begin
            $display("%0t: sample_out mismatch, expected %h, actual %h",
                     $time, want, m_tdata);
            mismatch_count++;
          end
        end
        out_stall = pick_gap();
      end
      // one long hold so the pipeline fills and input backs up
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall = LONG_HOLD;
      end
      if (out_stall > 0) begin
        out_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      REG_DRIVE_GAIN: drive_q = int'(data);
      REG_RANGE_GAIN: range_q = int'(data);
      REG_WET_MIX:    wet_q = int'((data > MIX_ONE) ? MIX_ONE : data);
      REG_AUTO_LEVEL: auto_q = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [CFG_DATA_W-1:0] drive, input logic [CFG_DATA_W-1:0] rng,
                         input logic [CFG_DATA_W-1:0] wet, input logic [CFG_DATA_W-1:0] lvl);
    write_reg(REG_DRIVE_GAIN, drive);
    write_reg(REG_RANGE_GAIN, rng);
    write_reg(REG_WET_MIX, wet);
    write_reg(REG_AUTO_LEVEL, lvl);
  endtask

  // wait until every sample is back, then let the pipeline empty
  task automatic settle();
    do begin
      @(negedge clk);
    end while (dry_samples.size() != 0 || s_tvalid || shaped_samples.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_gain_reg();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end
    if (r == 1) begin
      return 16'hFFFF;
    end
    if (r < 6) begin
      return CFG_DATA_W'($urandom_range(0, 1024));
    end
    return CFG_DATA_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [SW-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    case (r)
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return SW'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int p, i, r;
    logic [CFG_DATA_W-1:0] wet;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values: zero gain, fully dry
    @(negedge clk);
    dry_samples = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
    settle();

    // largest gain saturates the argument, blend write above one clamps,
    // auto level keeps only bit 0, unknown indexes ignored
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
    write_reg(8'd4, 16'h1234);
    write_reg(8'hFF, 16'hFFFF);
    @(negedge clk);
    dry_samples = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h0000};
    settle();

    // auto level with gain far above four
    write_reg(REG_AUTO_LEVEL, 16'h0003);
    @(negedge clk);
    dry_samples = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
    settle();

    // gain exactly 4.0 leaves the level alone
    set_all(16'd512, 16'd512, 16'd16384, 16'd1);
    @(negedge clk);
    dry_samples = '{16'h7FFF, 16'h8000, 16'd12345, -16'sd12345};
    settle();

    // gain just above 4.0
    set_all(16'd512, 16'd513, 16'd32767, 16'd1);
    @(negedge clk);
    dry_samples = '{16'h7FFF, 16'h8000, 16'd100};
    settle();

    // random settings, each followed by a burst of random samples
    for (p = 0; p < 8; p++) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        wet = '0;
      end else if (r == 1) begin
        wet = MIX_ONE;
      end else if (r == 2) begin
        wet = CFG_DATA_W'($urandom_range(32769, 65535));
      end else begin
        wet = CFG_DATA_W'($urandom_range(0, 32768));
      end
      set_all(pick_gain_reg(), pick_gain_reg(), wet, CFG_DATA_W'($urandom_range(0, 65535)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CFG_ADDR_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom_range(0, 65535)));
      end
      idle_off = (p == 5);
      @(negedge clk);
      for (i = 0; i < 50; i++) begin
        dry_samples.push_back(pick_sample());
      end
      if (p == 3) begin
        long_hold_req = 1'b1;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/atsc_pkg.sv
rtl/atan_soft_clip_distortion_unit.sv
sim/testbench.sv
